>>> rtl/core/double_ended_queue_assert.svh
// Assertion macros used by the checker of the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DEQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int Capacity = 16;
  localparam int WordBits = 16;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                en;
    cmd_e                cmd;
    logic [WordBits-1:0] word;
  } cell_ctrl_t;

endpackage

>>> rtl/core/deq_if.sv
`timescale 1ns / 1ps

interface deq_in_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  cmd_e                cmd;
  logic [WordBits-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic                valid;
  logic                ready;
  logic [WordBits-1:0] pop_value;
  status_e             status;
  logic                is_empty;
  logic                is_full;

  modport source (output valid, output pop_value, output status, output is_empty,
                  output is_full, input ready);
  modport sink (input valid, input pop_value, input status, input is_empty,
                input is_full, output ready);
endinterface

>>> rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of Capacity words, built as a chain of cells with
// the front word always in the first cell. Pushing or popping at the front
// shifts every cell one place in the same cycle; the back end is the boundary
// between occupied and free cells, so every operation updates the whole chain
// at once. One word is accepted per cycle unless the output stalls; its result
// appears in the output register on the next cycle. A new word is taken
// whenever that register is empty or being drained in the same cycle. A push
// into a full queue reports overflow and is dropped, and a pop from an empty
// queue reports underflow; neither changes the contents.
module double_ended_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);
  import deq_pkg::*;

  logic [WordBits-1:0] word_w [Capacity];
  logic [WordBits-1:0] tap_w  [Capacity];
  logic [Capacity-1:0] occ_w;
  cell_ctrl_t          ctrl;

  logic                accept;
  logic                is_push;
  logic                full_now;
  logic                empty_now;
  logic                ok;
  logic [WordBits-1:0] back_word;

  logic                out_valid_q;
  logic [WordBits-1:0] pop_value_q, pop_value_d;
  status_e             status_q, status_d;
  logic                empty_q, empty_d;
  logic                full_q, full_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign is_push    = (in_i.cmd == CMD_PUSH_FRONT) || (in_i.cmd == CMD_PUSH_BACK);
  assign full_now   = occ_w[Capacity-1];
  assign empty_now  = !occ_w[0];
  assign ok         = is_push ? !full_now : !empty_now;

  assign ctrl.en   = accept && ok;
  assign ctrl.cmd  = in_i.cmd;
  assign ctrl.word = in_i.push_value;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [WordBits-1:0] left_word, right_word;
    logic                left_occ, right_occ;

    // The chain's front takes the pushed word; its far end sees an empty cell.
    if (i == 0) begin : g_head
      assign left_word = in_i.push_value;
      assign left_occ  = 1'b1;
    end else begin : g_body
      assign left_word = word_w[i-1];
      assign left_occ  = occ_w[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_word = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner
      assign right_word = word_w[i+1];
      assign right_occ  = occ_w[i+1];
    end

    deq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_word_i (left_word),
      .left_occ_i  (left_occ),
      .right_word_i(right_word),
      .right_occ_i (right_occ),
      .word_o      (word_w[i]),
      .occ_o       (occ_w[i]),
      .tap_o       (tap_w[i])
    );
  end

  // At most one cell drives a nonzero tap.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < Capacity; i++) begin
      back_word = back_word | tap_w[i];
    end
  end

  always_comb begin
    pop_value_d = '0;
    status_d    = ST_OK;
    empty_d     = empty_now;
    full_d      = full_now;
    if (!ok) begin
      status_d = is_push ? ST_OVERFLOW : ST_UNDERFLOW;
    end else if (is_push) begin
      empty_d = 1'b0;
      full_d  = occ_w[Capacity-2];
    end else begin
      pop_value_d = (in_i.cmd == CMD_POP_FRONT) ? word_w[0] : back_word;
      empty_d     = !occ_w[1];
      full_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      empty_q     <= empty_d;
      full_q      <= full_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pop_value = pop_value_q;
  assign out_o.status    = status_q;
  assign out_o.is_empty  = empty_q;
  assign out_o.is_full   = full_q;

endmodule

>>> rtl/core/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  deq_pkg::cell_ctrl_t          ctrl_i,
  input  logic [deq_pkg::WordBits-1:0] left_word_i,
  input  logic                         left_occ_i,
  input  logic [deq_pkg::WordBits-1:0] right_word_i,
  input  logic                         right_occ_i,
  output logic [deq_pkg::WordBits-1:0] word_o,
  output logic                         occ_o,
  output logic [deq_pkg::WordBits-1:0] tap_o
);
  import deq_pkg::*;

  logic [WordBits-1:0] word_q, word_d;
  logic                occ_q, occ_d;
  logic                is_last;

  // The back word sits in the last occupied cell of the chain.
  assign is_last = occ_q && !right_occ_i;

  always_comb begin
    word_d = word_q;
    occ_d  = occ_q;
    if (ctrl_i.en) begin
      case (ctrl_i.cmd)
        CMD_PUSH_FRONT: begin
          word_d = left_word_i;
          occ_d  = left_occ_i;
        end
        CMD_PUSH_BACK: begin
          if (left_occ_i && !occ_q) begin
            word_d = ctrl_i.word;
            occ_d  = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          word_d = right_word_i;
          occ_d  = right_occ_i;
        end
        CMD_POP_BACK: begin
          if (is_last) begin
            occ_d = 1'b0;
          end
        end
        default: begin
          occ_d = occ_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign occ_o  = occ_q;
  assign tap_o  = is_last ? word_q : '0;

endmodule

>>> rtl/core/deq_checker.sv
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module deq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [deq_pkg::WordBits-1:0] out_pop_value_i,
  input deq_pkg::status_e             out_status_i,
  input logic                         out_is_empty_i,
  input logic                         out_is_full_i
);
  import deq_pkg::*;

  `DEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_pop_value_i) && $stable(out_status_i), "result word changed while stalled")
  `DEQ_ASSERT_IMPL(a_flags_excl, clk_i, rst_ni, out_valid_i, !(out_is_empty_i && out_is_full_i), "queue reported both empty and full")
  `DEQ_ASSERT_IMPL(a_overflow_full, clk_i, rst_ni, out_valid_i && (out_status_i == ST_OVERFLOW), out_is_full_i && (out_pop_value_i == '0), "overflow reported on a queue that is not full")
  `DEQ_ASSERT_IMPL(a_underflow_empty, clk_i, rst_ni, out_valid_i && (out_status_i == ST_UNDERFLOW), out_is_empty_i && (out_pop_value_i == '0), "underflow reported on a queue that is not empty")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_pop_value_i(out_o.pop_value),
  .out_status_i   (out_o.status),
  .out_is_empty_i (out_o.is_empty),
  .out_is_full_i  (out_o.is_full)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  typedef struct {
    cmd_e                cmd;
    logic [WordBits-1:0] push_value;
  } deq_op_t;

  typedef struct {
    logic [WordBits-1:0] pop_value;
    status_e             status;
    logic                is_empty;
    logic                is_full;
  } deq_result_t;

  localparam int RandomOps = 1026;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  deq_in_if  in_if ();
  deq_out_if out_if ();

  double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the deque contents, kept as a ring, unlike the block's shifting chain of cells.
  logic [WordBits-1:0] ring_words [Capacity];
  int unsigned         head_slot;
  int unsigned         tail_slot;
  int unsigned         word_count;

  deq_op_t     pending_ops[$];
  deq_result_t awaited_results[$];

  int  words_in;
  int  results_seen;
  int  mismatches;
  int  push_count;
  int  pop_count;
  int  overflow_count;
  int  underflow_count;
  bit  word_taken;

  function automatic deq_result_t predict_deque_op(deq_op_t op);
    deq_result_t res;
    res.pop_value = '0;
    res.status    = ST_OK;
    if (op.cmd == CMD_PUSH_FRONT || op.cmd == CMD_PUSH_BACK) begin
      if (word_count >= Capacity) begin
        res.status = ST_OVERFLOW;
        overflow_count++;
      end else begin
        if (op.cmd == CMD_PUSH_FRONT) begin
          head_slot = (head_slot == 0) ? Capacity - 1 : head_slot - 1;
          ring_words[head_slot] = op.push_value;
        end else begin
          ring_words[tail_slot] = op.push_value;
          tail_slot = (tail_slot + 1) % Capacity;
        end
        word_count++;
        push_count++;
      end
    end else begin
      if (word_count == 0) begin
        res.status = ST_UNDERFLOW;
        underflow_count++;
      end else begin
        if (op.cmd == CMD_POP_FRONT) begin
          res.pop_value = ring_words[head_slot];
          head_slot = (head_slot + 1) % Capacity;
        end else begin
          tail_slot = (tail_slot == 0) ? Capacity - 1 : tail_slot - 1;
          res.pop_value = ring_words[tail_slot];
        end
        word_count--;
        pop_count++;
      end
    end
    res.is_empty = (word_count == 0);
    res.is_full  = (word_count >= Capacity);
    return res;
  endfunction

  task automatic queue_op(cmd_e cmd, logic [WordBits-1:0] value);
    deq_op_t op;
    op.cmd        = cmd;
    op.push_value = value;
    pending_ops.push_back(op);
  endtask

  function automatic logic [WordBits-1:0] pick_word();
    int bit_pos;
    bit_pos = $urandom_range(WordBits - 1);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return WordBits'(1) << bit_pos;
      3: return ~(WordBits'(1) << bit_pos);
      default: return WordBits'($urandom);
    endcase
  endfunction

  // Driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin : drive_words
    int send_idle;
    int recv_idle;
    if (words_in < 350) begin
      send_idle = 10;
      recv_idle = 47;
    end else if (words_in < 700) begin
      send_idle = 47;
      recv_idle = 10;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
      if (in_if.valid && !word_taken) begin
        // Hold the offered word until the block takes it.
      end else if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid      <= 1'b1;
        in_if.cmd        <= pending_ops[0].cmd;
        in_if.push_value <= pending_ops[0].push_value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted word, checks every accepted result.
  always @(posedge clk_i) begin : watch_ports
    deq_result_t want;
    word_taken = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        word_taken = 1'b1;
        awaited_results.push_back(predict_deque_op(pending_ops.pop_front()));
        words_in++;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result pop_value=%h status=%s", $time,
                   out_if.pop_value, out_if.status.name());
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_if.pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %h actual %h", $time,
                     want.pop_value, out_if.pop_value);
            mismatches++;
          end
          if (out_if.status !== want.status) begin
            $display("%0t: status expected %s actual %s", $time,
                     want.status.name(), out_if.status.name());
            mismatches++;
          end
          if (out_if.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time,
                     want.is_empty, out_if.is_empty);
            mismatches++;
          end
          if (out_if.is_full !== want.is_full) begin
            $display("%0t: is_full expected %b actual %b", $time,
                     want.is_full, out_if.is_full);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int fill_plan;
    int burst_left;
    int push_pct;
    bit is_push;
    cmd_e cmd;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_PUSH_FRONT;
    in_if.push_value = '0;
    out_if.ready     = 1'b0;
    head_slot        = 0;
    tail_slot        = 0;
    word_count       = 0;

    // Underflow at both ends, then a short round trip through both ends.
    queue_op(CMD_POP_FRONT, '1);
    queue_op(CMD_POP_BACK, '1);
    queue_op(CMD_PUSH_BACK, '0);
    queue_op(CMD_PUSH_FRONT, '1);
    queue_op(CMD_POP_FRONT, '0);
    queue_op(CMD_POP_BACK, '1);
    // Fill from both ends so the front index wraps, then overflow at both ends.
    for (int k = 0; k < Capacity; k++) begin
      queue_op((k % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
               (k % 4 < 2) ? WordBits'(16'h8000 >> k) : ~WordBits'(16'h0001 << k));
    end
    queue_op(CMD_PUSH_FRONT, 16'hA5A5);
    queue_op(CMD_PUSH_BACK, 16'h5A5A);

    // Random bursts that lean toward filling, draining or neither, so the
    // queue keeps crossing between empty and full.
    fill_plan  = Capacity;
    burst_left = 0;
    push_pct   = 50;
    for (int n = 0; n < RandomOps; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 6);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      is_push = ($urandom_range(99) < push_pct);
      if (is_push) begin
        cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (fill_plan < Capacity) fill_plan++;
      end else begin
        cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if (fill_plan > 0) fill_plan--;
      end
      queue_op(cmd, pick_word());
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() > 0 || awaited_results.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d words and checked %0d results: %0d pushes, %0d pops,",
             words_in, results_seen, push_count, pop_count);
    $display("%0d overflows, %0d underflows, %0d mismatches.",
             overflow_count, underflow_count, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
